FILE: sv/lmd_pkg.sv
// Shared types and constants of the 3x3 local maximum detector.
// No dependencies; used by every module of the block.
package lmd_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int PIX_W        = 16;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int DIM_W        = 11;
  localparam int RES_PER_ITEM = 4;
  localparam int SEL_W        = $clog2(RES_PER_ITEM);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = FIFO_AW + 1;
  localparam int ADDR_W       = 4;
  localparam int REG_W        = 2;
  localparam int DATA_W       = 32;

  localparam logic [REG_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_STRICT = 2'd2;
  localparam logic [REG_W-1:0] REG_BORDER = 2'd3;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef pix_t [0:2][0:2] win_t;
  typedef logic [2*PIX_W-1:0] lbuf_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             last_row;
  } meta_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             strict;
    logic             incl_border;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             value;
    logic             is_max;
    logic             last;
  } res_t;

  typedef res_t [RES_PER_ITEM-1:0] slots_t;

  typedef struct packed {
    slots_t                  slot;
    logic [RES_PER_ITEM-1:0] mask;
  } bundle_t;

endpackage

FILE: sv/local_maximum_3x3_detector_unit.sv
// Top level of the 3x3 local maximum detector: register port, raster counters,
// stall control. Depends on lmd_pkg, lmd_window, lmd_judge and lmd_out_fifo.
//
// Takes one signed pixel per cycle in raster order while in_stall is low and
// reports, per pixel, its row, column, value and whether it is a 3x3 local
// maximum (strict or non-strict, border pixels optional). A pixel is judged as
// soon as its window is complete; the item that completes it passes the s1 and s2
// registers, and its results then leave a four-entry queue one per cycle while
// out_stall is low. Each entry holds all results of one input item (none in the
// first row, one per pixel after the first in inner rows, two at each row end, two
// per pixel after the first in the last row and four at its end). The single
// result port sets the rate: one item per cycle in all rows but the last, fewer
// there. Line memory: one 1024 x 32 array with one read and one write per cycle.
// Writing frame_width or frame_height restarts the frame at row 0, column 0.
module local_maximum_3x3_detector_unit (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_pixel,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [9:0]                  out_row,
  output logic [9:0]                  out_col,
  output logic signed [15:0]          out_value,
  output logic                        out_is_max,
  output logic                        out_last,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lmd_pkg::ADDR_W-1:0]  paddr,
  input  logic [lmd_pkg::DATA_W-1:0]  pwdata,
  output logic [lmd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [lmd_pkg::DIM_W-1:0] frame_width_r;
  logic [lmd_pkg::DIM_W-1:0] frame_height_r;
  logic                      strict_r;
  logic                      border_r;

  logic [lmd_pkg::ROW_W-1:0] row_r;
  logic [lmd_pkg::COL_W-1:0] col_r;

  logic [lmd_pkg::REG_W-1:0] reg_idx;
  logic                      cfg_wr;
  logic                      in_acc;
  lmd_pkg::cfg_t             cfg;
  lmd_pkg::meta_t            meta;

  logic [1:0]                inflight;
  logic                      s2_v;
  lmd_pkg::meta_t            s2_meta;
  lmd_pkg::win_t             win;
  lmd_pkg::bundle_t          bnd;
  lmd_pkg::res_t             res;
  logic [lmd_pkg::CNT_W-1:0] fifo_cnt;
  logic                      push;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lmd_pkg::REG_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      lmd_pkg::REG_WIDTH:  prdata = lmd_pkg::DATA_W'(frame_width_r);
      lmd_pkg::REG_HEIGHT: prdata = lmd_pkg::DATA_W'(frame_height_r);
      lmd_pkg::REG_STRICT: prdata = lmd_pkg::DATA_W'(strict_r);
      lmd_pkg::REG_BORDER: prdata = lmd_pkg::DATA_W'(border_r);
      default:             prdata = '0;
    endcase
  end

  // effective geometry, clamped to 1..max
  always_comb begin
    if (frame_width_r == '0) begin
      cfg.width = lmd_pkg::DIM_W'(1);
    end else if (frame_width_r > lmd_pkg::DIM_W'(lmd_pkg::MAX_WIDTH)) begin
      cfg.width = lmd_pkg::DIM_W'(lmd_pkg::MAX_WIDTH);
    end else begin
      cfg.width = frame_width_r;
    end
    if (frame_height_r == '0) begin
      cfg.height = lmd_pkg::DIM_W'(1);
    end else if (frame_height_r > lmd_pkg::DIM_W'(lmd_pkg::MAX_HEIGHT)) begin
      cfg.height = lmd_pkg::DIM_W'(lmd_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = frame_height_r;
    end
    cfg.strict      = strict_r;
    cfg.incl_border = border_r;
  end

  assign meta.row      = row_r;
  assign meta.col      = col_r;
  assign meta.last_col = lmd_pkg::DIM_W'(col_r) >= cfg.width - lmd_pkg::DIM_W'(1);
  assign meta.last_row = lmd_pkg::DIM_W'(row_r) >= cfg.height - lmd_pkg::DIM_W'(1);

  // room for this item's entry and those still in the pipeline
  assign in_stall = (lmd_pkg::CNT_W'(fifo_cnt) + lmd_pkg::CNT_W'(inflight))
                    >= lmd_pkg::CNT_W'(lmd_pkg::FIFO_DEPTH);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lmd_pkg::DIM_W'(5);
      frame_height_r <= lmd_pkg::DIM_W'(5);
      strict_r       <= 1'b0;
      border_r       <= 1'b0;
      row_r          <= '0;
      col_r          <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        lmd_pkg::REG_WIDTH: begin
          frame_width_r <= pwdata[lmd_pkg::DIM_W-1:0];
          row_r         <= '0;
          col_r         <= '0;
        end
        lmd_pkg::REG_HEIGHT: begin
          frame_height_r <= pwdata[lmd_pkg::DIM_W-1:0];
          row_r          <= '0;
          col_r          <= '0;
        end
        lmd_pkg::REG_STRICT: strict_r <= pwdata[0];
        lmd_pkg::REG_BORDER: border_r <= pwdata[0];
        default: ;
      endcase
    end else if (in_acc) begin
      if (meta.last_col) begin
        col_r <= '0;
        row_r <= meta.last_row ? '0 : row_r + lmd_pkg::ROW_W'(1);
      end else begin
        col_r <= col_r + lmd_pkg::COL_W'(1);
      end
    end
  end

  lmd_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .px       (in_pixel),
    .meta     (meta),
    .inflight (inflight),
    .s2_v     (s2_v),
    .s2_meta  (s2_meta),
    .win      (win)
  );

  lmd_judge u_judge (
    .win  (win),
    .meta (s2_meta),
    .cfg  (cfg),
    .bnd  (bnd)
  );

  assign push = s2_v && (bnd.mask != '0);

  lmd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bnd       (bnd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .cnt       (fifo_cnt)
  );

  assign out_row    = res.row;
  assign out_col    = res.col;
  assign out_value  = res.value;
  assign out_is_max = res.is_max;
  assign out_last   = res.last;

endmodule

FILE: sv/lmd_window.sv
// Line memory (upper and middle rows per column) and the 3x3 window registers.
// Depends on lmd_pkg.
module lmd_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  lmd_pkg::pix_t  px,
  input  lmd_pkg::meta_t meta,
  output logic [1:0]     inflight,
  output logic           s2_v,
  output lmd_pkg::meta_t s2_meta,
  output lmd_pkg::win_t  win
);

  lmd_pkg::lbuf_word_t lbuf_mem [lmd_pkg::MAX_WIDTH];
  lmd_pkg::lbuf_word_t rd_r;

  logic           s1_v_r;
  lmd_pkg::pix_t  s1_px_r;
  lmd_pkg::meta_t s1_meta_r;
  logic           byp_r;
  lmd_pkg::pix_t  fwd_up_r;
  lmd_pkg::pix_t  fwd_mid_r;

  logic           s2_v_r;
  lmd_pkg::meta_t s2_meta_r;
  lmd_pkg::win_t  win_r;
  lmd_pkg::win_t  win_nxt;

  lmd_pkg::pix_t  eff_up;
  lmd_pkg::pix_t  eff_mid;

  // same column written by the item ahead: take its values instead of the stale read
  assign eff_up  = byp_r ? fwd_up_r  : rd_r[2*lmd_pkg::PIX_W-1:lmd_pkg::PIX_W];
  assign eff_mid = byp_r ? fwd_mid_r : rd_r[lmd_pkg::PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= lbuf_mem[meta.col];
    end
    if (s1_v_r) begin
      lbuf_mem[s1_meta_r.col] <= {eff_mid, s1_px_r};
    end
  end

  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = eff_up;
    win_nxt[1][2] = eff_mid;
    win_nxt[2][2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r   <= px;
      s1_meta_r <= meta;
      byp_r     <= s1_v_r && (s1_meta_r.col == meta.col);
      fwd_up_r  <= eff_mid;
      fwd_mid_r <= s1_px_r;
    end
    if (s1_v_r) begin
      win_r     <= win_nxt;
      s2_meta_r <= s1_meta_r;
    end
  end

  assign inflight = 2'(s1_v_r) + 2'(s2_v_r);
  assign s2_v     = s2_v_r;
  assign s2_meta  = s2_meta_r;
  assign win      = win_r;

endmodule

FILE: sv/lmd_judge.sv
// Judges the up to four pixels that one window position completes.
// Depends on lmd_pkg.
module lmd_judge (
  input  lmd_pkg::win_t   win,
  input  lmd_pkg::meta_t  meta,
  input  lmd_pkg::cfg_t   cfg,
  output lmd_pkg::bundle_t bnd
);

  function automatic lmd_pkg::res_t judge_px(
    input lmd_pkg::win_t                win_in,
    input int                           cy,
    input int                           cx,
    input logic [lmd_pkg::ROW_W-1:0]    cr,
    input logic [lmd_pkg::COL_W-1:0]    cc,
    input lmd_pkg::cfg_t                c
  );
    lmd_pkg::res_t              res;
    logic [lmd_pkg::DIM_W-1:0]  cr_e;
    logic [lmd_pkg::DIM_W-1:0]  cc_e;
    logic                       border;
    logic                       ok;
    logic                       in_frame;
    int                         wy;
    int                         wx;
    lmd_pkg::pix_t              a;
    lmd_pkg::pix_t              nb;
    cr_e   = lmd_pkg::DIM_W'(cr);
    cc_e   = lmd_pkg::DIM_W'(cc);
    a      = win_in[cy][cx];
    border = (cr_e == '0) || (cc_e == '0) ||
             (cr_e == c.height - lmd_pkg::DIM_W'(1)) ||
             (cc_e == c.width - lmd_pkg::DIM_W'(1));
    ok = 1'b1;
    if (border && !c.incl_border) begin
      ok = 1'b0;
    end else begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          wy = cy + dy;
          wx = cx + dx;
          in_frame = 1'b1;
          if (dy < 0 && cr_e == '0) in_frame = 1'b0;
          if (dy > 0 && cr_e + lmd_pkg::DIM_W'(1) >= c.height) in_frame = 1'b0;
          if (dx < 0 && cc_e == '0) in_frame = 1'b0;
          if (dx > 0 && cc_e + lmd_pkg::DIM_W'(1) >= c.width) in_frame = 1'b0;
          // neighbors past the newest row or column are not in the window yet
          if ((dy != 0 || dx != 0) && wy <= 2 && wx <= 2 && in_frame) begin
            nb = win_in[wy][wx];
            if (c.strict ? (nb >= a) : (nb > a)) ok = 1'b0;
          end
        end
      end
    end
    res.row    = cr;
    res.col    = cc;
    res.value  = a;
    res.is_max = ok;
    res.last   = (cr_e == c.height - lmd_pkg::DIM_W'(1)) &&
                 (cc_e == c.width - lmd_pkg::DIM_W'(1));
    return res;
  endfunction

  logic [lmd_pkg::ROW_W-1:0] rm1;
  logic [lmd_pkg::COL_W-1:0] cm1;
  logic                      r_nz;
  logic                      c_nz;

  assign rm1  = meta.row - lmd_pkg::ROW_W'(1);
  assign cm1  = meta.col - lmd_pkg::COL_W'(1);
  assign r_nz = (meta.row != '0);
  assign c_nz = (meta.col != '0);

  // slot order is raster order of the judged pixels
  always_comb begin
    bnd.slot[0] = judge_px(win, 1, 1, rm1, cm1, cfg);
    bnd.slot[1] = judge_px(win, 1, 2, rm1, meta.col, cfg);
    bnd.slot[2] = judge_px(win, 2, 1, meta.row, cm1, cfg);
    bnd.slot[3] = judge_px(win, 2, 2, meta.row, meta.col, cfg);
    bnd.mask[0] = r_nz && c_nz;
    bnd.mask[1] = r_nz && meta.last_col;
    bnd.mask[2] = meta.last_row && c_nz;
    bnd.mask[3] = meta.last_row && meta.last_col;
  end

endmodule

FILE: sv/lmd_out_fifo.sv
// Result queue: one entry per item holds up to four results, sent one per cycle while out_stall is low.
// Depends on lmd_pkg.
module lmd_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lmd_pkg::bundle_t            bnd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lmd_pkg::res_t               res,
  output logic [lmd_pkg::CNT_W-1:0]   cnt
);

  lmd_pkg::slots_t                  slot_q_r [lmd_pkg::FIFO_DEPTH];
  logic [lmd_pkg::RES_PER_ITEM-1:0] mask_q_r [lmd_pkg::FIFO_DEPTH];
  logic [lmd_pkg::FIFO_AW-1:0]      rd_ptr_r;
  logic [lmd_pkg::FIFO_AW-1:0]      wr_ptr_r;
  logic [lmd_pkg::CNT_W-1:0]        cnt_r;
  logic [lmd_pkg::CNT_W-1:0]        cnt_nxt;

  logic [lmd_pkg::RES_PER_ITEM-1:0] head_mask;
  logic [lmd_pkg::RES_PER_ITEM-1:0] sel_oh;
  logic [lmd_pkg::RES_PER_ITEM-1:0] rest_mask;
  logic [lmd_pkg::SEL_W-1:0]        sel_idx;
  logic                             pop_res;
  logic                             pop_bnd;

  assign head_mask = mask_q_r[rd_ptr_r];

  always_comb begin
    sel_idx = '0;
    for (int i = lmd_pkg::RES_PER_ITEM - 1; i >= 0; i--) begin
      if (head_mask[i]) sel_idx = lmd_pkg::SEL_W'(i);
    end
  end

  assign sel_oh    = lmd_pkg::RES_PER_ITEM'(1) << sel_idx;
  assign rest_mask = head_mask & ~sel_oh;
  assign out_valid = (cnt_r != '0);
  assign pop_res   = out_valid && !out_stall;
  assign pop_bnd   = pop_res && (rest_mask == '0);
  assign res       = slot_q_r[rd_ptr_r][sel_idx];
  assign cnt       = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop_bnd) cnt_nxt = cnt_r + lmd_pkg::CNT_W'(1);
    if (!push && pop_bnd) cnt_nxt = cnt_r - lmd_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + lmd_pkg::FIFO_AW'(1);
      if (pop_bnd) rd_ptr_r <= rd_ptr_r + lmd_pkg::FIFO_AW'(1);
    end
  end

  // a push never lands on the head entry while it is being drained
  always_ff @(posedge clk) begin
    if (push) begin
      slot_q_r[wr_ptr_r] <= bnd.slot;
      mask_q_r[wr_ptr_r] <= bnd.mask;
    end
    if (pop_res) begin
      mask_q_r[rd_ptr_r] <= rest_mask;
    end
  end

endmodule
